/* rtl/dry_delay_crossfade_mixer_top_assert.svh */
// assertion macros used by the top-level rtl file
`ifndef DRY_DELAY_CROSSFADE_MIXER_TOP_ASSERT_SVH
`define DRY_DELAY_CROSSFADE_MIXER_TOP_ASSERT_SVH
`ifndef SYNTH
`define DCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dcm assertion failed");
`define DCM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dcm assertion failed");
`else
`define DCM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define DCM_ASSERT_SAME(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/dcm_pkg.sv */
package dcm_pkg;

	localparam int DELAY_DEPTH = 65536;
	localparam int SAMPLE_W    = 16;
	localparam int ADDR_W      = $clog2(DELAY_DEPTH);
	localparam int FILL_W      = ADDR_W + 1;
	localparam int CFG_W       = 16;
	localparam int LEVEL_W     = 16;
	localparam int CFG_IDX_W   = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_LATENCY  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FADE_IN  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FADE_OUT = 2'd2;

	localparam logic [CFG_W-1:0] DEFAULT_LATENCY  = 16'd20160;
	localparam logic [CFG_W-1:0] DEFAULT_FADE_IN  = 16'd114;
	localparam logic [CFG_W-1:0] DEFAULT_FADE_OUT = 16'd170;

	// one half in the Q0.16 level scale (half an lsb after the 16-bit shift), for rounding
	localparam int ROUND_HALF = 1 << (LEVEL_W - 1);

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		sample_t left_in;
		sample_t right_in;
		sample_t converted_sample;
		logic    converted_ready;
		logic    discard;
		logic    block_last;
	} frame_t;

	typedef struct packed {
		sample_t left_out;
		sample_t right_out;
		sample_t mono_out;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LVL,
		ST_MIX,
		ST_FIN
	} state_t;

endpackage

/* rtl/dcm_blend.sv */
module dcm_blend (
	input  logic                             clk,
	input  logic                             mul_en,
	input  dcm_pkg::sample_t                 dry,
	input  dcm_pkg::sample_t                 target,
	input  logic [dcm_pkg::LEVEL_W-1:0]      level,
	output dcm_pkg::sample_t                 result
);
	import dcm_pkg::*;

	localparam int DIFF_W = SAMPLE_W + 1;
	localparam int PROD_W = DIFF_W + LEVEL_W + 1;
	localparam int SH_W   = PROD_W - LEVEL_W;
	localparam int SUM_W  = SH_W + 1;

	logic signed [DIFF_W-1:0] diff;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [PROD_W-1:0] rounded;
	logic signed [SH_W-1:0]   shifted;
	logic signed [SUM_W-1:0]  sum;

	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((1 << (SAMPLE_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

	assign diff = $signed({target[SAMPLE_W-1], target}) - $signed({dry[SAMPLE_W-1], dry});
	assign prod = PROD_W'(diff * $signed({1'b0, level}));

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= prod;
		end
	end

	// floor of the rounded product over 2^16, then a saturating add
	assign rounded = prod_q + PROD_W'(ROUND_HALF);
	assign shifted = rounded[PROD_W-1:LEVEL_W];
	assign sum     = SUM_W'(shifted) + SUM_W'(dry);

	always_comb begin
		if (sum > SAT_HI) begin
			result = SAT_HI[SAMPLE_W-1:0];
		end else if (sum < SAT_LO) begin
			result = SAT_LO[SAMPLE_W-1:0];
		end else begin
			result = sum[SAMPLE_W-1:0];
		end
	end

endmodule

/* rtl/dry_delay_crossfade_mixer_top.sv */
// an accepted frame passes the level, mix and finish states before mix result valid,
// holding in finish on an output stall; no new frame until the four-step sequencer
//   is idle (memory read and level product, level update, blend products, blend sum)
// reset (arst_n low, asynchronous): pointer, fill count, mix level, held sample
//   and sequencer cleared, config registers back to defaults; delay memory is not
//   cleared, the fill count keeps unwritten entries from being used
module dry_delay_crossfade_mixer_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           frame_valid,
	output logic                           frame_stall,
	input  dcm_pkg::frame_t                frame,
	output logic                           mix_valid,
	input  logic                           mix_stall,
	output dcm_pkg::result_t               mix,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dcm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dcm_pkg::CFG_W-1:0]      cfg_data
);
	import dcm_pkg::*;

	`include "dry_delay_crossfade_mixer_top_assert.svh"

	localparam int MUL_W  = LEVEL_W + 1;
	localparam int LPROD_W = MUL_W + CFG_W;

	// configuration registers
	logic [CFG_W-1:0] latency_q;
	logic [CFG_W-1:0] fade_in_q;
	logic [CFG_W-1:0] fade_out_q;

	// core state
	state_t              state_q;
	state_t              state_d;
	logic [ADDR_W-1:0]   wp_q;
	logic [FILL_W-1:0]   fill_q;
	logic [LEVEL_W-1:0]  mix_level_q;
	sample_t             held_q;

	// per-frame working registers
	logic                hit_q;
	logic                ready_q;
	logic [LEVEL_W-1:0]  m_base_q;
	logic [LPROD_W-1:0]  lvl_prod_q;
	sample_t             target_q;
	sample_t             mono_q;
	sample_t             dry_l_q;
	sample_t             dry_r_q;

	// output register
	logic                mix_valid_q;
	result_t             mix_q;

	// delay line, left in the upper half of each word
	logic [2*SAMPLE_W-1:0] delay_mem [DELAY_DEPTH];
	logic [2*SAMPLE_W-1:0] rdata_q;

	logic                accept;
	logic                out_free;
	logic [31:0]         lat_w;
	logic [ADDR_W-1:0]   rd_addr;
	logic                hit;
	logic [LEVEL_W-1:0]  m_base;
	logic [MUL_W-1:0]    mul_a;
	logic [CFG_W-1:0]    mul_b;
	logic [LPROD_W-1:0]  lvl_prod;
	logic [LPROD_W:0]    lvl_round;
	logic [MUL_W-1:0]    delta;
	logic [MUL_W:0]      rise;
	logic [LEVEL_W-1:0]  level_next;
	logic signed [SAMPLE_W:0] mono_sum;
	sample_t             blend_l;
	sample_t             blend_r;

	assign cfg_ready   = 1'b1;
	assign frame_stall = (state_q != ST_IDLE);
	assign accept      = frame_valid && !frame_stall;
	assign out_free    = !mix_valid_q || !mix_stall;
	assign mix_valid   = mix_valid_q;
	assign mix         = mix_q;

	// config writes; unknown index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latency_q  <= DEFAULT_LATENCY;
			fade_in_q  <= DEFAULT_FADE_IN;
			fade_out_q <= DEFAULT_FADE_OUT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_LATENCY:  latency_q  <= cfg_data;
				CFG_FADE_IN:  fade_in_q  <= cfg_data;
				CFG_FADE_OUT: fade_out_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective latency: zero means the default, then clamp to the line length
	always_comb begin
		lat_w = 32'(latency_q == '0 ? DEFAULT_LATENCY : latency_q);
		if (lat_w > 32'(DELAY_DEPTH - 1)) begin
			lat_w = 32'(DELAY_DEPTH - 1);
		end
	end

	// ring wraps naturally at a power-of-two depth
	assign rd_addr = wp_q - lat_w[ADDR_W-1:0];
	assign hit     = 32'(fill_q) >= lat_w;

	// level product, taken on the level after a discard
	always_comb begin
		m_base = frame.discard ? '0 : mix_level_q;
		if (frame.converted_ready) begin
			mul_a = MUL_W'(1 << LEVEL_W) - {1'b0, m_base};
			mul_b = fade_in_q;
		end else begin
			mul_a = {1'b0, m_base};
			mul_b = fade_out_q;
		end
		lvl_prod = LPROD_W'(mul_a * mul_b);
	end

	assign mono_sum = $signed({frame.left_in[SAMPLE_W-1], frame.left_in})
		+ $signed({frame.right_in[SAMPLE_W-1], frame.right_in});

	// memory: write the new frame, read the delayed one, both on the accept edge
	always_ff @(posedge clk) begin
		if (accept) begin
			delay_mem[wp_q] <= {frame.left_in, frame.right_in};
			rdata_q         <= delay_mem[rd_addr];
		end
	end

	// level update from the registered product
	always_comb begin
		lvl_round = {1'b0, lvl_prod_q} + (LPROD_W + 1)'(ROUND_HALF);
		delta     = lvl_round[LEVEL_W +: MUL_W];
		rise      = {2'b00, m_base_q} + {1'b0, delta};
		if (ready_q) begin
			if (rise > (MUL_W + 1)'((1 << LEVEL_W) - 1)) begin
				level_next = '1;
			end else begin
				level_next = rise[LEVEL_W-1:0];
			end
		end else if (delta >= {1'b0, m_base_q}) begin
			level_next = '0;
		end else begin
			level_next = m_base_q - delta[LEVEL_W-1:0];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_LVL;
				end
			end
			ST_LVL:  state_d = ST_MIX;
			ST_MIX:  state_d = ST_FIN;
			ST_FIN: begin
				// hold the blend until the output register can take it
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			fill_q      <= '0;
			mix_level_q <= '0;
			held_q      <= '0;
			mix_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				wp_q <= wp_q + ADDR_W'(1);
				if (fill_q < FILL_W'(DELAY_DEPTH)) begin
					fill_q <= fill_q + FILL_W'(1);
				end
				// held sample: cleared by discard, latched on a ready block end
				if (frame.converted_ready && frame.block_last) begin
					held_q <= frame.converted_sample;
				end else if (frame.discard) begin
					held_q <= '0;
				end
			end
			if (state_q == ST_LVL) begin
				mix_level_q <= level_next;
			end
			if (state_q == ST_FIN && out_free) begin
				mix_valid_q <= 1'b1;
			end else if (mix_valid_q && !mix_stall) begin
				mix_valid_q <= 1'b0;
			end
		end
	end

	// per-frame payload
	always_ff @(posedge clk) begin
		if (accept) begin
			hit_q      <= hit;
			ready_q    <= frame.converted_ready;
			m_base_q   <= m_base;
			lvl_prod_q <= lvl_prod;
			mono_q     <= mono_sum[SAMPLE_W:1];
			if (frame.converted_ready) begin
				target_q <= frame.converted_sample;
			end else begin
				target_q <= frame.discard ? '0 : held_q;
			end
		end
		if (state_q == ST_LVL) begin
			// dry path is silent until the line holds enough frames
			dry_l_q <= hit_q ? rdata_q[2*SAMPLE_W-1:SAMPLE_W] : '0;
			dry_r_q <= hit_q ? rdata_q[SAMPLE_W-1:0] : '0;
		end
		if (state_q == ST_FIN && out_free) begin
			mix_q.left_out  <= blend_l;
			mix_q.right_out <= blend_r;
			mix_q.mono_out  <= mono_q;
		end
	end

	// one blend lane per channel
	dcm_blend u_blend_l (
		.clk    (clk),
		.mul_en (state_q == ST_MIX),
		.dry    (dry_l_q),
		.target (target_q),
		.level  (mix_level_q),
		.result (blend_l)
	);

	dcm_blend u_blend_r (
		.clk    (clk),
		.mul_en (state_q == ST_MIX),
		.dry    (dry_r_q),
		.target (target_q),
		.level  (mix_level_q),
		.result (blend_r)
	);

	// a transaction always starts the level step
	`DCM_ASSERT_NEXT(a_accept_to_lvl, clk, arst_n, accept, state_q == ST_LVL)
	// a finished blend with room lands in the output register
	`DCM_ASSERT_NEXT(a_fin_loads_out, clk, arst_n, state_q == ST_FIN && out_free, mix_valid_q)
	// the fill count moves by one per frame until it saturates
	`DCM_ASSERT_NEXT(a_fill_step, clk, arst_n, accept && fill_q < FILL_W'(DELAY_DEPTH),
		fill_q == $past(fill_q) + FILL_W'(1))
	// a rising level never drops below its starting point
	`DCM_ASSERT_NEXT(a_rise_monotone, clk, arst_n, state_q == ST_LVL && ready_q,
		mix_level_q >= $past(m_base_q))
	// no new frame while the sequencer is busy
	`DCM_ASSERT_SAME(a_busy_stalls, clk, arst_n, state_q != ST_IDLE, frame_stall)

endmodule
